>>> rtl/core/bloom_filter_insert_query_top_defines.svh
// Assertion macros shared by the Bloom filter checker.
`ifndef BLOOM_FILTER_INSERT_QUERY_TOP_DEFINES_SVH
`define BLOOM_FILTER_INSERT_QUERY_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define BFQ_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Next-cycle implication, checked outside reset.
`define BFQ_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) ante |=> cons) else $error(msg);

`endif

>>> rtl/core/bfq_pkg.sv
// Types and constants for the Bloom filter block.
`default_nettype none
package bfq_pkg;

  localparam int unsigned WORDS      = 1024;
  localparam int unsigned WORD_AW    = $clog2(WORDS);
  localparam int unsigned MAX_PROBES = 32;
  localparam logic [16:0] COUNT_MAX  = 17'h1FFFF;

  localparam logic [63:0] MM_C1 = 64'h87c37b91114253d5;
  localparam logic [63:0] MM_C2 = 64'h4cf5ad432745937f;
  localparam logic [63:0] MM_F1 = 64'hff51afd7ed558ccd;
  localparam logic [63:0] MM_F2 = 64'hc4ceb9fe1a85ec53;

  typedef struct packed {
    logic        op;
    logic [63:0] key;
  } bfq_in_t;

  typedef struct packed {
    logic        answer;
    logic [16:0] set_bits;
  } bfq_out_t;

  typedef enum logic [1:0] {
    CFG_WORDS  = 2'd0,
    CFG_HASHES = 2'd1,
    CFG_SEED   = 2'd2
  } cfg_idx_e;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_QUERY  = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_HASH, ST_MUL, ST_DIV, ST_READ, ST_CHECK, ST_DONE
  } state_e;

  typedef enum logic [3:0] {
    PH_K1, PH_ROT, PH_MIX, PH_AB, PH_BA, PH_FA1, PH_FA2, PH_FA3,
    PH_FB2, PH_FB3, PH_AB2, PH_BA2
  } hash_ph_e;

  typedef enum logic [1:0] {
    MC_C1, MC_C2, MC_F1, MC_F2
  } mconst_e;

endpackage
`default_nettype wire

>>> rtl/core/bloom_filter_insert_query_top.sv
// Top level of the Bloom filter with insert and query over a 64-bit word store.
`default_nettype none
// Each transaction carries an operation and a 64-bit key and yields exactly one result
// transaction. After reset the block clears all 1024 words of the bit store and takes no
// transaction meanwhile; configuration writes are taken at any time. An item is then
// hashed, with one 32x32 multiplier computing the six 64-bit products of MurmurHash3
// from three partial products each, followed for each probe by a three-bit-per-cycle
// remainder unit that maps the probe onto the words in use, a store read and a check
// with write-back. A query stops at its first clear bit and a hash count of zero skips
// the hashing. Only one item is in work at a time, but a finished result may wait in
// the output register while the next item is taken.
module bloom_filter_insert_query_top
  import bfq_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [31:0] cfg_data_i,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire bfq_in_t  in_data_i,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  output bfq_out_t      out_data_o
);

  // Configuration registers.
  logic [10:0] words_q;
  logic [5:0]  hashes_q;
  logic [31:0] seed_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      words_q  <= 11'(WORDS);
      hashes_q <= 6'd7;
      seed_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_WORDS:  words_q  <= cfg_data_i[10:0];
        CFG_HASHES: hashes_q <= cfg_data_i[5:0];
        CFG_SEED:   seed_q   <= cfg_data_i;
        default:    ;
      endcase
    end
  end

  // Clamped word count and probe count.
  logic [10:0] wu;
  logic [5:0]  hc;
  assign wu = (words_q == 11'd0) ? 11'd1 :
              (words_q > 11'(WORDS)) ? 11'(WORDS) : words_q;
  assign hc = (hashes_q > 6'(MAX_PROBES)) ? 6'(MAX_PROBES) : hashes_q;

  // Sequencer and datapath registers.
  state_e       st_q, st_d;
  hash_ph_e     ph_q, ph_d;
  mconst_e      cs_q, cs_d;
  logic [1:0]   ms_q, ms_d;
  logic [WORD_AW-1:0] clr_q, clr_d;
  logic [63:0]  x_q, x_d, a_q, a_d, b_q, b_d, acc_q, acc_d, comb_q, comb_d;
  logic [56:0]  dv_q, dv_d;
  logic [10:0]  r_q, r_d;
  logic [4:0]   dc_q, dc_d;
  logic [5:0]   pc_q, pc_d;
  logic         op_q, op_d, ans_q, ans_d;
  logic [16:0]  cnt_q, cnt_d;
  logic         out_valid_q, out_valid_d;
  bfq_out_t     out_q, out_d;

  // Bit store with a registered read port.
  logic [63:0]        mem_q [WORDS];
  logic [63:0]        rdata_q;
  logic               mem_we;
  logic [WORD_AW-1:0] waddr;
  logic [63:0]        wdata;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[waddr] <= wdata;
    end
    rdata_q <= mem_q[r_q[WORD_AW-1:0]];
  end

  // Shared 32x32 multiplier: x times the selected constant, one partial product a cycle.
  logic [63:0] mconst;
  logic [31:0] m_a, m_b;
  logic [63:0] prod;
  always_comb begin
    case (cs_q)
      MC_C1:   mconst = MM_C1;
      MC_C2:   mconst = MM_C2;
      MC_F1:   mconst = MM_F1;
      MC_F2:   mconst = MM_F2;
      default: mconst = MM_C1;
    endcase
  end
  assign m_a  = (ms_q == 2'd1) ? x_q[63:32] : x_q[31:0];
  assign m_b  = (ms_q == 2'd2) ? mconst[63:32] : mconst[31:0];
  assign prod = 64'(m_a) * 64'(m_b);

  // Remainder unit: three dividend bits a cycle against the word count.
  logic [10:0] r_nx;
  always_comb begin
    logic [11:0] t;
    r_nx = r_q;
    for (int k = 0; k < 3; k++) begin
      t = {r_nx, dv_q[56 - k]};
      if (t >= 12'(wu)) begin
        t = t - 12'(wu);
      end
      r_nx = t[10:0];
    end
  end

  logic [63:0] comb_nx;
  logic        bit_hit;
  logic [63:0] seed8;
  assign comb_nx = comb_q + b_q;
  assign bit_hit = rdata_q[comb_q[5:0]];
  assign seed8   = {32'd0, seed_q} ^ 64'd8;

  // Next state and datapath control.
  always_comb begin
    st_d = st_q; ph_d = ph_q; cs_d = cs_q; ms_d = ms_q; clr_d = clr_q;
    x_d = x_q; a_d = a_q; b_d = b_q; acc_d = acc_q; comb_d = comb_q;
    dv_d = dv_q; r_d = r_q; dc_d = dc_q; pc_d = pc_q;
    op_d = op_q; ans_d = ans_q; cnt_d = cnt_q;
    out_valid_d = out_valid_q; out_d = out_q;
    mem_we = 1'b0; waddr = clr_q; wdata = '0;
    in_ready_o = (st_q == ST_IDLE);

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (st_q)
      ST_CLEAR: begin
        mem_we = 1'b1;
        clr_d  = clr_q + 1'b1;
        if (clr_q == WORD_AW'(WORDS - 1)) begin
          st_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          x_d   = in_data_i.key;
          op_d  = in_data_i.op;
          ans_d = (in_data_i.op == OP_QUERY) && (hc != 6'd0);
          pc_d  = '0;
          ph_d  = PH_K1;
          st_d  = (hc == 6'd0) ? ST_DONE : ST_HASH;
        end
      end
      ST_HASH: begin
        case (ph_q)
          PH_K1: begin
            cs_d = MC_C1; ms_d = '0; ph_d = PH_ROT; st_d = ST_MUL;
          end
          PH_ROT: begin
            x_d  = {x_q[32:0], x_q[63:33]};
            cs_d = MC_C2; ms_d = '0; ph_d = PH_MIX; st_d = ST_MUL;
          end
          PH_MIX: begin
            a_d = seed8 ^ x_q; b_d = seed8; ph_d = PH_AB;
          end
          PH_AB: begin
            a_d = a_q + b_q; ph_d = PH_BA;
          end
          PH_BA: begin
            b_d = b_q + a_q; ph_d = PH_FA1;
          end
          PH_FA1: begin
            x_d  = a_q ^ (a_q >> 33);
            cs_d = MC_F1; ms_d = '0; ph_d = PH_FA2; st_d = ST_MUL;
          end
          PH_FA2: begin
            x_d  = x_q ^ (x_q >> 33);
            cs_d = MC_F2; ms_d = '0; ph_d = PH_FA3; st_d = ST_MUL;
          end
          PH_FA3: begin
            a_d  = x_q ^ (x_q >> 33);
            x_d  = b_q ^ (b_q >> 33);
            cs_d = MC_F1; ms_d = '0; ph_d = PH_FB2; st_d = ST_MUL;
          end
          PH_FB2: begin
            x_d  = x_q ^ (x_q >> 33);
            cs_d = MC_F2; ms_d = '0; ph_d = PH_FB3; st_d = ST_MUL;
          end
          PH_FB3: begin
            b_d = x_q ^ (x_q >> 33); ph_d = PH_AB2;
          end
          PH_AB2: begin
            a_d = a_q + b_q; ph_d = PH_BA2;
          end
          PH_BA2: begin
            // h1 is final here; h2 lands in b.
            b_d    = b_q + a_q;
            comb_d = a_q;
            dv_d   = a_q[62:6];
            r_d    = '0;
            dc_d   = '0;
            st_d   = ST_DIV;
          end
          default: st_d = ST_IDLE;
        endcase
      end
      ST_MUL: begin
        ms_d = ms_q + 2'd1;
        case (ms_q)
          2'd0:    acc_d = prod;
          2'd1:    acc_d = acc_q + {prod[31:0], 32'd0};
          default: begin
            x_d  = acc_q + {prod[31:0], 32'd0};
            st_d = ST_HASH;
          end
        endcase
      end
      ST_DIV: begin
        r_d  = r_nx;
        dv_d = {dv_q[53:0], 3'd0};
        dc_d = dc_q + 5'd1;
        if (dc_q == 5'd18) begin
          st_d = ST_READ;
        end
      end
      ST_READ: begin
        st_d = ST_CHECK;
      end
      ST_CHECK: begin
        if (op_q == OP_INSERT && !bit_hit) begin
          mem_we = 1'b1;
          waddr  = r_q[WORD_AW-1:0];
          wdata  = rdata_q | (64'd1 << comb_q[5:0]);
          ans_d  = 1'b1;
          if (cnt_q != COUNT_MAX) begin
            cnt_d = cnt_q + 17'd1;
          end
        end
        if (op_q == OP_QUERY && !bit_hit) begin
          ans_d = 1'b0;
          st_d  = ST_DONE;
        end else if (pc_q + 6'd1 == hc) begin
          st_d = ST_DONE;
        end else begin
          pc_d   = pc_q + 6'd1;
          comb_d = comb_nx;
          dv_d   = comb_nx[62:6];
          r_d    = '0;
          dc_d   = '0;
          st_d   = ST_DIV;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d     = 1'b1;
          out_d.answer    = ans_q;
          out_d.set_bits  = cnt_q;
          st_d            = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_CLEAR;
      clr_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      clr_q       <= clr_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload and datapath registers.
  always_ff @(posedge clk_i) begin
    ph_q <= ph_d; cs_q <= cs_d; ms_q <= ms_d;
    x_q <= x_d; a_q <= a_d; b_q <= b_d; acc_q <= acc_d; comb_q <= comb_d;
    dv_q <= dv_d; r_q <= r_d; dc_q <= dc_d; pc_q <= pc_d;
    op_q <= op_d; ans_q <= ans_d; out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
`default_nettype wire

>>> rtl/core/bfq_checker.sv
// Port-level checker for the Bloom filter top level, with its bind.
`default_nettype none
`include "bloom_filter_insert_query_top_defines.svh"
module bfq_checker
  import bfq_pkg::*;
(
  input wire logic     clk_i,
  input wire logic     rst_ni,
  input wire logic     in_valid_i,
  input wire logic     in_ready_o,
  input wire logic     out_valid_o,
  input wire logic     out_ready_i,
  input wire bfq_out_t out_data_o
);

  // Count of set bits seen in the last result transaction.
  logic [16:0] last_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q <= '0;
    end else if (out_valid_o && out_ready_i) begin
      last_q <= out_data_o.set_bits;
    end
  end

  `BFQ_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o, "result dropped")
  `BFQ_ASSERT_NEXT(a_out_stable, out_valid_o && !out_ready_i, $stable(out_data_o), "result changed")
  `BFQ_ASSERT(a_count_mono, out_valid_o |-> out_data_o.set_bits >= last_q, "count went down")
  `BFQ_ASSERT_NEXT(a_busy, in_valid_i && in_ready_o, !in_ready_o, "ready after accept")

endmodule

bind bloom_filter_insert_query_top bfq_checker u_bfq_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
`default_nettype wire
